// File: src/mtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtg_pkg;
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int KEY_MAX      = 16;
    localparam int AW           = 10;
    localparam int KW           = 4;
    localparam int KCW          = 5;

    localparam logic [1:0] OP_SEED = 2'd0;
    localparam logic [1:0] OP_KEY  = 2'd1;
    localparam logic [1:0] OP_GEN  = 2'd2;

    localparam logic [31:0] MIX_A   = 32'h9908b0df;
    localparam logic [31:0] HI_BIT  = 32'h80000000;
    localparam logic [31:0] LO_BITS = 32'h7fffffff;
    localparam logic [31:0] MUL_S   = 32'd1812433253;
    localparam logic [31:0] MUL_K1  = 32'd1664525;
    localparam logic [31:0] MUL_K2  = 32'd1566083941;
    localparam logic [31:0] SEED_AR = 32'd19650218;
    localparam logic [31:0] SEED_DF = 32'd5489;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic        last;
    } t_cmd;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage
`default_nettype wire

// File: src/mtg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry command queue; drops op 3.
module mtg_front
    import mtg_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_cmd   i_cmd,
    output logic        o_full,
    output logic        o_valid,
    output t_cmd        o_cmd,
    input  wire logic   i_take
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_in, w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_in    = i_push && !o_full && (i_cmd.op != 2'd3);
    assign w_out   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end
endmodule
`default_nettype wire

// File: src/mtg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer over the 624-word store. Store has one write and one read port;
// a twist step reads three words in turn, an array step one, then it writes.
module mtg_back
    import mtg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_take,
    output logic             o_rvalid,
    output logic [31:0]      o_word,
    input  wire logic        i_rpop
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SS = 4'd1, S_A1R = 4'd2, S_A1C = 4'd3,
        S_A2R = 4'd4, S_A2C = 4'd5, S_TR = 4'd6, S_TR2 = 4'd7, S_TR3 = 4'd8,
        S_TC = 4'd9, S_OR = 4'd10, S_OW = 4'd11, S_MUL = 4'd12, S_FIX = 4'd13,
        S_A1W = 4'd14, S_A2W = 4'd15;

    logic [31:0] r_mem [STATE_WORDS];
    logic [31:0] r_key [KEY_MAX];
    logic [31:0] r_rd;
    logic [3:0]  r_st, r_ret;
    logic [AW-1:0] r_idx, r_a, r_n, r_p;
    logic [KCW-1:0] r_kc, r_len;
    logic [KW-1:0] r_b;
    logic        r_gen, r_arr, r_ov;
    logic [31:0] r_prev, r_cur, r_prod, r_out;
    logic [AW-1:0] w_ra;
    logic        w_we;
    logic [AW-1:0] w_wa;
    logic [31:0] w_wd;
    logic [31:0] w_y;

    assign o_take   = (r_st == S_IDLE) && i_valid && !(i_cmd.op == OP_GEN && r_ov);
    assign o_rvalid = r_ov;
    assign o_word   = r_out;

    always_comb begin
        w_y = (r_prev & HI_BIT) | (r_cur & LO_BITS);
    end

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        return (v >= (AW+1)'(STATE_WORDS)) ? AW'(v - (AW+1)'(STATE_WORDS)) : v[AW-1:0];
    endfunction

    always_comb begin
        w_ra = r_a;
        case (r_st)
            S_TR:  w_ra = r_p;
            S_TR2: w_ra = wrap({1'b0, r_p} + (AW+1)'(1));
            S_TR3: w_ra = wrap({1'b0, r_p} + (AW+1)'(TWIST_OFFSET));
            S_A1R, S_A2R: w_ra = r_a;
            S_OR:  w_ra = r_idx;
            default: w_ra = r_a;
        endcase
    end

    always_comb begin
        w_we = 1'b0; w_wa = r_a; w_wd = r_prod;
        case (r_st)
            S_FIX: begin w_we = 1'b1; w_wa = r_p; w_wd = r_prod; end
            S_A1W: begin
                w_we = 1'b1; w_wa = r_a;
                w_wd = (r_cur ^ r_prod) + r_key[r_b] + 32'(r_b);
            end
            S_A2W: begin
                w_we = 1'b1; w_wa = r_a;
                w_wd = (r_cur ^ r_prod) - 32'(r_a);
            end
            S_TC: begin
                w_we = 1'b1; w_wa = r_p;
                w_wd = r_rd ^ (w_y >> 1) ^ (w_y[0] ? MIX_A : 32'd0);
            end
            // end of array seeding: store[0] <- high bit
            S_OW: if (!r_gen) begin
                w_we = 1'b1; w_wa = '0; w_wd = HI_BIT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
        if (o_take && i_cmd.op == OP_KEY && r_kc < KCW'(KEY_MAX))
            r_key[r_kc[KW-1:0]] <= i_cmd.value;
    end

    // Three word products (MUL_S, MUL_K1, MUL_K2) in separate states; one per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_idx <= AW'(STATE_WORDS + 1); r_kc <= '0; r_ov <= 1'b0;
            r_gen <= 1'b0; r_arr <= 1'b0;
        end else begin
            if (r_ov && i_rpop) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (o_take) begin
                    r_gen <= (i_cmd.op == OP_GEN);
                    r_arr <= (i_cmd.op == OP_KEY) && i_cmd.last;
                    case (i_cmd.op)
                        OP_SEED: begin
                            r_prev <= i_cmd.value; r_p <= '0; r_st <= S_FIX;
                            r_prod <= i_cmd.value;
                        end
                        OP_KEY: begin
                            if (i_cmd.last) begin
                                r_len <= (r_kc < KCW'(KEY_MAX)) ? r_kc + KCW'(1) : r_kc;
                                r_kc <= '0;
                                r_prev <= SEED_AR; r_prod <= SEED_AR; r_p <= '0;
                                r_st <= S_FIX;
                            end else if (r_kc < KCW'(KEY_MAX)) r_kc <= r_kc + KCW'(1);
                        end
                        OP_GEN: begin
                            if (r_idx == AW'(STATE_WORDS + 1)) begin
                                r_prev <= SEED_DF; r_prod <= SEED_DF; r_p <= '0;
                                r_st <= S_FIX;
                            end else if (r_idx == AW'(STATE_WORDS)) begin
                                r_p <= '0; r_st <= S_TR;
                            end else r_st <= S_OR;
                        end
                        default: ;
                    endcase
                end
                // scalar seed: write r_prod at r_p, then multiply
                S_FIX: begin
                    if (r_p == AW'(STATE_WORDS - 1)) begin
                        r_idx <= AW'(STATE_WORDS);
                        if (r_arr) begin
                            r_prev <= SEED_AR;
                            r_a <= AW'(1); r_b <= '0; r_n <= AW'(STATE_WORDS);
                            r_st <= S_A1R;
                        end else if (r_gen) begin
                            r_p <= '0; r_st <= S_TR;
                        end else r_st <= S_IDLE;
                    end else begin
                        r_prev <= r_prod;
                        r_p <= r_p + AW'(1);
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= MUL_S * (r_prev ^ (r_prev >> 30)) + 32'(r_p);
                    r_st <= S_FIX;
                end
                // array phase 1: r_prev holds store[a-1]
                S_A1R: r_st <= S_A1C;
                S_A1C: begin
                    r_cur <= r_rd;
                    r_prod <= (r_prev ^ (r_prev >> 30)) * MUL_K1;
                    r_st <= S_A1W;
                end
                S_A1W, S_A2W: begin
                    r_prev <= w_wd;
                    if (r_st == S_A1W)
                        r_b <= ({1'b0, r_b} + KCW'(1) >= r_len) ? '0 : r_b + KW'(1);
                    if (r_a == AW'(STATE_WORDS - 1)) begin
                        r_a <= AW'(1);
                        r_ret <= r_st;
                        r_n <= r_n - AW'(1);
                        r_st <= S_SS;
                    end else if (r_n != AW'(1)) begin
                        r_a <= r_a + AW'(1);
                        r_n <= r_n - AW'(1);
                        r_st <= (r_st == S_A1W) ? S_A1R : S_A2R;
                    end else if (r_st == S_A1W) begin
                        r_a <= r_a + AW'(1);
                        r_n <= AW'(STATE_WORDS - 1);
                        r_st <= S_A2R;
                    end else begin
                        r_a <= r_a + AW'(1);
                        r_n <= '0;
                        r_st <= S_OW;
                    end
                end
                // wrap: store[0] is not written; r_prev holds store[last] in its place
                S_SS: begin
                    r_p <= '0; r_prod <= r_prev;
                    r_st <= (r_ret == S_A1W && r_n != '0) ? S_A1R :
                            (r_ret == S_A2W && r_n == '0) ? S_OW : S_A2R;
                end
                S_A2R: begin
                    if (r_st == S_A2R && r_ret == S_A1W && r_n == '0) begin
                        r_ret <= S_A2W; r_n <= AW'(STATE_WORDS - 1);
                    end
                    r_st <= S_A2C;
                end
                S_A2C: begin
                    r_cur <= r_rd;
                    r_prod <= (r_prev ^ (r_prev >> 30)) * MUL_K2;
                    r_st <= S_A2W;
                end
                S_TR:  r_st <= S_TR2;
                S_TR2: begin r_prev <= r_rd; r_st <= S_TR3; end
                S_TR3: begin r_cur <= r_rd; r_st <= S_TC; end
                S_TC: begin
                    if (r_p == AW'(STATE_WORDS - 1)) begin
                        r_idx <= '0; r_st <= S_OR;
                    end else begin
                        r_p <= r_p + AW'(1); r_st <= S_TR;
                    end
                end
                S_OR: r_st <= S_OW;
                S_OW: begin
                    if (r_gen) begin
                        r_out <= temper(r_rd); r_ov <= 1'b1;
                        r_idx <= r_idx + AW'(1);
                        r_st <= S_IDLE;
                    end else begin
                        r_idx <= AW'(STATE_WORDS); r_arr <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/mersenne_twister_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake      | payload
// in      | push/full      | i_op, i_value, i_last
// out     | empty/pop      | o_random_word
// Generate tempers a stored word, twisting the store when used up.
// Scalar seed writes a word then multiplies; array seed adds key mixing.
// Reset is synchronous active low; the store is not cleared.
// The input queue holds 2; the store has one read and one write port.
module mersenne_twister_generator_top
    import mtg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_value,
    input  wire logic        i_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_random_word
);
    t_cmd w_in, w_cmd;
    logic w_v, w_take, w_ov;

    assign w_in = '{op: i_op, value: i_value, last: i_last};

    mtg_front u_front (.i_clk, .i_rst_n, .i_push(push), .i_cmd(w_in), .o_full(full),
        .o_valid(w_v), .o_cmd(w_cmd), .i_take(w_take));

    mtg_back u_back (.i_clk, .i_rst_n, .i_valid(w_v), .i_cmd(w_cmd), .o_take(w_take),
        .o_rvalid(w_ov), .o_word(o_random_word), .i_rpop(pop));

    assign empty = !w_ov;

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n) w_take |-> w_v)
        else $error("take from empty queue");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_random_word)))
        else $error("result lost");
endmodule
`default_nettype wire

// File: tb/sv/mersenne_twister_generator_top_test.sv
`timescale 1ns / 1ps
module mersenne_twister_generator_top_test;
    import mtg_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 40000000;
    localparam int RANDOM_ITEMS = 1880;
    localparam int DRAIN_CYCLES = 12000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_op = OP_GEN;
    logic [31:0] i_value = '0;
    logic        i_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_random_word;

    mersenne_twister_generator_top uut (.*);

    always #6 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic        last;
        logic        known;
        logic [31:0] word;
    } t_row;

    t_row directed_rows [22] = '{
        '{OP_GEN,    32'h0,        1'b0, 1'b1, 32'd3499211612},
        '{OP_GEN,    32'hffffffff, 1'b1, 1'b1, 32'd581869302},
        '{OP_UNUSED, 32'hffffffff, 1'b1, 1'b0, 32'h0},
        '{OP_GEN,    32'h0,        1'b0, 1'b1, 32'd3890346734},
        '{OP_SEED,   32'd5489,     1'b0, 1'b0, 32'h0},
        '{OP_GEN,    32'h0,        1'b0, 1'b1, 32'd3499211612},
        '{OP_KEY,    32'h123,      1'b0, 1'b0, 32'h0},
        '{OP_KEY,    32'h234,      1'b0, 1'b0, 32'h0},
        '{OP_KEY,    32'h345,      1'b0, 1'b0, 32'h0},
        '{OP_KEY,    32'h456,      1'b1, 1'b0, 32'h0},
        '{OP_GEN,    32'h0,        1'b0, 1'b1, 32'd1067595299},
        '{OP_GEN,    32'h0,        1'b0, 1'b1, 32'd955945823},
        '{OP_SEED,   32'h0,        1'b0, 1'b0, 32'h0},
        '{OP_GEN,    32'h0,        1'b0, 1'b0, 32'h0},
        '{OP_SEED,   32'hffffffff, 1'b1, 1'b0, 32'h0},
        '{OP_GEN,    32'h0,        1'b0, 1'b0, 32'h0},
        '{OP_KEY,    32'hffffffff, 1'b0, 1'b0, 32'h0},
        '{OP_SEED,   32'd12345,    1'b0, 1'b0, 32'h0},
        '{OP_KEY,    32'h0,        1'b1, 1'b0, 32'h0},
        '{OP_GEN,    32'h0,        1'b0, 1'b0, 32'h0},
        '{OP_KEY,    32'haaaaaaaa, 1'b1, 1'b0, 32'h0},
        '{OP_GEN,    32'h0,        1'b0, 1'b0, 32'h0}
    };

    // generator shadow state
    logic [31:0] mt_store [STATE_WORDS];
    int          mt_index = STATE_WORDS + 1;
    logic [31:0] key_words [KEY_MAX];
    int          key_fill = 0;

    logic [31:0] pending_words [$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          cycles = 0;

    function automatic logic [31:0] fold(input logic [31:0] x);
        return x ^ (x >> 30);
    endfunction

    function automatic void fill_linear(input logic [31:0] s);
        mt_store[0] = s;
        for (int p = 1; p < STATE_WORDS; p++)
            mt_store[p] = MUL_S * fold(mt_store[p-1]) + 32'(p);
        mt_index = STATE_WORDS;
    endfunction

    function automatic void fill_from_keys(input int len);
        int a;
        int b;
        int n;
        a = 1;
        b = 0;
        fill_linear(SEED_AR);
        if (len == 0) len = 1;
        n = (STATE_WORDS > len) ? STATE_WORDS : len;
        for (; n != 0; n--) begin
            mt_store[a] = (mt_store[a] ^ (fold(mt_store[a-1]) * MUL_K1))
                          + key_words[b] + 32'(b);
            a++;
            b++;
            if (a >= STATE_WORDS) begin
                mt_store[0] = mt_store[STATE_WORDS-1];
                a = 1;
            end
            if (b >= len) b = 0;
        end
        for (n = STATE_WORDS - 1; n != 0; n--) begin
            mt_store[a] = (mt_store[a] ^ (fold(mt_store[a-1]) * MUL_K2)) - 32'(a);
            a++;
            if (a >= STATE_WORDS) begin
                mt_store[0] = mt_store[STATE_WORDS-1];
                a = 1;
            end
        end
        mt_store[0] = HI_BIT;
        mt_index = STATE_WORDS;
    endfunction

    function automatic void twist_store();
        logic [31:0] y;
        for (int p = 0; p < STATE_WORDS; p++) begin
            y = (mt_store[p] & HI_BIT) | (mt_store[(p+1) % STATE_WORDS] & LO_BITS);
            mt_store[p] = mt_store[(p + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1)
                          ^ (y[0] ? MIX_A : 32'h0);
        end
        mt_index = 0;
    endfunction

    function automatic logic [31:0] next_tempered();
        logic [31:0] y;
        if (mt_index >= STATE_WORDS) begin
            if (mt_index != STATE_WORDS) fill_linear(SEED_DF);
            twist_store();
        end
        y = mt_store[mt_index];
        mt_index++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        return y ^ (y >> 18);
    endfunction

    function automatic void apply_command(input t_row r);
        logic [31:0] w;
        case (r.op)
            OP_SEED: fill_linear(r.value);
            OP_KEY: begin
                if (key_fill < KEY_MAX) begin
                    key_words[key_fill] = r.value;
                    key_fill++;
                end
                if (r.last) begin
                    fill_from_keys(key_fill);
                    key_fill = 0;
                end
            end
            OP_GEN: begin
                w = next_tempered();
                pending_words.push_back(r.known ? r.word : w);
            end
            default: ;
        endcase
    endfunction

    task automatic send(input t_row r);
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_op    <= r.op;
        i_value <= r.value;
        i_last  <= r.last;
        do @(posedge i_clk); while (full);
        apply_command(r);
    endtask

    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (pending_words.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected transfer: random_word %h", o_random_word);
                mismatches++;
            end else begin
                if (o_random_word !== pending_words[0]) begin
                    if (mismatches < 10)
                        $display("random_word mismatch: expected %h actual %h",
                                 pending_words[0], o_random_word);
                    mismatches++;
                end
                void'(pending_words.pop_front());
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (!i_rst_n || hold_left > 0) begin
            if (hold_left > 0) hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_row r;
        int   phase;
        int   sent;
        int   klen;
        int   pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send(directed_rows[k]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = sent * 4 / RANDOM_ITEMS;
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            if (sent >= 20 && hold_req == 0) hold_req++;
            r.known = 1'b0;
            r.word = '0;
            r.value = $urandom;
            r.last = $urandom_range(0, 1);
            pick = $urandom_range(0, 999);
            if (pick < 10) begin
                r.op = OP_SEED;
                send(r);
                sent++;
            end else if (pick < 16) begin
                // key sequence, sometimes longer than the buffer
                klen = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20)
                                                   : $urandom_range(1, 16);
                for (int j = 0; j < klen; j++) begin
                    r.op = OP_KEY;
                    r.value = $urandom;
                    r.last = (j == klen - 1);
                    send(r);
                    sent++;
                end
            end else if (pick < 40) begin
                r.op = OP_UNUSED;
                send(r);
            end else begin
                r.op = OP_GEN;
                send(r);
                sent++;
            end
        end
        push <= 1'b0;
        stall_pct = 0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: filelist.f
src/mtg_pkg.sv
src/mtg_front.sv
src/mtg_back.sv
src/mersenne_twister_generator_top.sv
tb/sv/mersenne_twister_generator_top_test.sv
